// File: design/ebbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_pkg
// Shared widths, limits and handshake structs of the line box blur block.
// ----------------------------------------------------------------------------
package ebbl_pkg;

  // field and state widths
  localparam int PIX_W  = 8;
  localparam int RAD_W  = 6;
  localparam int SUM_W  = 15;
  localparam int SEEN_W = 7;
  localparam int DIVR_W = 7;
  localparam int Q_W    = 8;

  // default largest radius
  localparam int MAX_RADIUS_DEF = 63;

  // pixel count saturates here
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  // request to the divider
  typedef struct packed {
    logic [SUM_W-1:0]  dividend;
    logic [DIVR_W-1:0] divisor;
    logic              last;
  } div_req_t;

  // result from the divider
  typedef struct packed {
    logic [Q_W-1:0] quot;
    logic           last;
  } div_res_t;

endpackage

// File: design/edge_normalized_box_blur_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_normalized_box_blur_line
// Sliding box mean over one line of 8-bit pixels, window clipped to the line
// and divided by the true pixel count; results lag by the radius.
// ----------------------------------------------------------------------------
//  channel  | direction | data                 | marker
//  s_axis   | in        | tdata[7:0] pixel_in  | tlast end_of_line
//  m_axis   | out       | tdata[7:0] pixel_out | tlast last_of_line
//  cfg      | in        | cfg_data_i blur_rad. | -
//
//  A pixel that makes a result holds off the next pixel until the 8-step
//  divider is free; a pixel inside the lag skips it, and each flushed
//  result at line end also runs through it. One RAM holds the pixel ring,
//  one write and one read a cycle. No clearing pass: stale entries may be
//  read but never enter the sum. A stalled output holds one result in the
//  output register and one in the divider, and the next pixel waits.
// ----------------------------------------------------------------------------
module edge_normalized_box_blur_line #(
  parameter int MAX_RADIUS = ebbl_pkg::MAX_RADIUS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slave stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ebbl_pkg::PIX_W-1:0] s_axis_tdata,  // [7:0] pixel_in
  input  logic                       s_axis_tlast,
  // master stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ebbl_pkg::PIX_W-1:0] m_axis_tdata,  // [7:0] pixel_out
  output logic                       m_axis_tlast,
  // config write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ebbl_pkg::RAD_W-1:0] cfg_data_i
);

  localparam int RING_AW    = $clog2(2 * MAX_RADIUS + 2);
  localparam int RING_DEPTH = 1 << RING_AW;
  localparam int RAD_W      = ebbl_pkg::RAD_W;
  localparam int SEEN_W     = ebbl_pkg::SEEN_W;
  localparam int SUM_W      = ebbl_pkg::SUM_W;
  localparam int PIX_W      = ebbl_pkg::PIX_W;
  localparam logic [RAD_W-1:0] RAD_LIM = RAD_W'(MAX_RADIUS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_WAIT_N,
    ST_FL_RD,
    ST_FL_SUB,
    ST_WAIT_F
  } state_e;

  state_e              state_q, state_d;
  logic [RAD_W-1:0]    blur_radius_q, blur_radius_d;
  logic [RAD_W-1:0]    rad_q, rad_d;
  logic [SEEN_W-1:0]   seen_q, seen_d;
  logic [RING_AW-1:0]  ptr_q, ptr_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RAD_W-1:0]    k_q, k_d;
  logic                eol_q, eol_d;
  logic                out_valid_q, out_valid_d;
  logic [PIX_W-1:0]    out_data_q, out_data_d;
  logic                out_last_q, out_last_d;

  logic                ram_we;
  logic                ram_re;
  logic [RING_AW-1:0]  ram_raddr;
  logic [PIX_W-1:0]    ram_rdata;

  logic                div_start;
  ebbl_pkg::div_req_t  div_req;
  logic                div_busy;
  logic                div_rv;
  logic                div_take;
  ebbl_pkg::div_res_t  div_res;

  logic                accept;
  logic                finish;
  logic [RAD_W-1:0]    rad_new;
  logic [SEEN_W-1:0]   r7;
  logic [SEEN_W-1:0]   k7;
  logic [SEEN_W-1:0]   span_n;
  logic [SEEN_W-1:0]   span_r;
  logic [SEEN_W-1:0]   dist_f;
  logic [SEEN_W-1:0]   ofs;
  logic [SEEN_W-1:0]   ofs_min;
  logic [SEEN_W-1:0]   kcount;
  logic [SEEN_W-1:0]   nk;
  logic [SEEN_W-1:0]   nk_min;
  logic                res_en;
  logic                drop_n;
  logic                drop_f;
  logic [SUM_W-1:0]    rd_ext;
  logic [SUM_W-1:0]    sum_drop_n;
  logic [SUM_W-1:0]    sum_drop_f;

  // pixel ring
  ebbl_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // mean divider
  ebbl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .req_i       (div_req),
    .busy_o      (div_busy),
    .res_valid_o (div_rv),
    .res_ready_i (div_take),
    .res_o       (div_res)
  );

  // window geometry
  always_comb begin
    rad_new    = (blur_radius_q > RAD_LIM) ? RAD_LIM : blur_radius_q;
    r7         = {1'b0, rad_q};
    k7         = {1'b0, k_q};
    span_n     = {rad_new, 1'b1};
    span_r     = {rad_q, 1'b1};
    dist_f     = k7 + r7 + SEEN_W'(2);
    res_en     = seen_q >= r7;
    drop_n     = seen_q >= span_r;
    ofs        = seen_q - r7;
    ofs_min    = (ofs < r7) ? ofs : r7;
    kcount     = res_en ? r7 : (seen_q + 1'b1);
    nk         = seen_q - k7;
    nk_min     = (nk < r7) ? nk : r7;
    drop_f     = nk > r7;
    rd_ext     = SUM_W'(ram_rdata);
    sum_drop_n = drop_n ? (sum_q - rd_ext) : sum_q;
    sum_drop_f = drop_f ? (sum_q - rd_ext) : sum_q;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign div_take      = div_rv & (~out_valid_q | m_axis_tready);

  // sequencer and output register
  always_comb begin
    state_d       = state_q;
    blur_radius_d = blur_radius_q;
    rad_d         = rad_q;
    seen_d        = seen_q;
    ptr_d         = ptr_q;
    sum_d         = sum_q;
    k_d           = k_q;
    eol_d         = eol_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;
    out_last_d    = out_last_q;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = ptr_q;
    div_start     = 1'b0;
    div_req       = '0;
    finish        = 1'b0;

    if (cfg_valid_i) begin
      blur_radius_d = cfg_data_i;
    end

    // output register
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (div_take) begin
      out_valid_d = 1'b1;
      out_data_d  = div_res.quot;
      out_last_d  = div_res.last;
    end

    case (state_q)
      ST_IDLE: begin
        // write new pixel, fetch the one leaving the window
        if (accept) begin
          ram_we    = 1'b1;
          ram_re    = 1'b1;
          if (seen_q == '0) begin
            rad_d     = rad_new;
            ram_raddr = ptr_q - span_n[RING_AW-1:0];
          end else begin
            ram_raddr = ptr_q - span_r[RING_AW-1:0];
          end
          ptr_d   = ptr_q + 1'b1;
          sum_d   = sum_q + SUM_W'(s_axis_tdata);
          eol_d   = s_axis_tlast;
          state_d = ST_SUB;
        end
      end
      ST_SUB: begin
        sum_d = sum_drop_n;
        if (res_en) begin
          div_start        = 1'b1;
          div_req.dividend = sum_drop_n;
          div_req.divisor  = ofs_min + r7 + 1'b1;
          div_req.last     = eol_q & (rad_q == '0);
          state_d          = ST_WAIT_N;
        end else if (eol_q) begin
          k_d     = RAD_W'(kcount - 1'b1);
          state_d = ST_FL_RD;
        end else begin
          finish  = 1'b1;
        end
      end
      ST_WAIT_N: begin
        if (!div_busy) begin
          if (eol_q && kcount != '0) begin
            k_d     = RAD_W'(kcount - 1'b1);
            state_d = ST_FL_RD;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_FL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = ptr_q - dist_f[RING_AW-1:0];
        state_d   = ST_FL_SUB;
      end
      ST_FL_SUB: begin
        sum_d            = sum_drop_f;
        div_start        = 1'b1;
        div_req.dividend = sum_drop_f;
        div_req.divisor  = nk_min + k7 + 1'b1;
        div_req.last     = (k_q == '0);
        state_d          = ST_WAIT_F;
      end
      ST_WAIT_F: begin
        if (!div_busy) begin
          if (k_q == '0) begin
            finish = 1'b1;
          end else begin
            k_d     = k_q - 1'b1;
            state_d = ST_FL_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // end of pixel work, line state returns to zero at line end
    if (finish) begin
      state_d = ST_IDLE;
      if (eol_q) begin
        sum_d  = '0;
        seen_d = '0;
        ptr_d  = '0;
      end else if (seen_q != ebbl_pkg::SEEN_MAX) begin
        seen_d = seen_q + 1'b1;
      end
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      blur_radius_q <= '0;
      rad_q         <= '0;
      seen_q        <= '0;
      ptr_q         <= '0;
      sum_q         <= '0;
      k_q           <= '0;
      eol_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      blur_radius_q <= blur_radius_d;
      rad_q         <= rad_d;
      seen_q        <= seen_d;
      ptr_q         <= ptr_d;
      sum_q         <= sum_d;
      k_q           <= k_d;
      eol_q         <= eol_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: design/ebbl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ebbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/ebbl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_div
// Restoring divider, one quotient bit per cycle, result held until taken.
// ----------------------------------------------------------------------------
module ebbl_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  ebbl_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output ebbl_pkg::div_res_t res_o
);

  localparam int CNT_W = $clog2(ebbl_pkg::Q_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ebbl_pkg::Q_W - 1);

  logic                        run_q, run_d;
  logic                        rv_q, rv_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [ebbl_pkg::SUM_W-1:0]  rem_q, rem_d;
  logic [ebbl_pkg::SUM_W-1:0]  dsh_q, dsh_d;
  logic [ebbl_pkg::Q_W-1:0]    quot_q, quot_d;
  logic                        last_q, last_d;
  logic                        geq;

  // one compare and subtract per step
  always_comb begin
    run_d  = run_q;
    rv_d   = rv_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    last_d = last_q;
    geq    = rem_q >= dsh_q;
    if (rv_q && res_ready_i) begin
      rv_d = 1'b0;
    end
    if (start_i) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend;
      dsh_d  = ebbl_pkg::SUM_W'({req_i.divisor, {(ebbl_pkg::Q_W-1){1'b0}}});
      quot_d = '0;
      last_d = req_i.last;
    end else if (run_q) begin
      if (geq) begin
        rem_d = rem_q - dsh_q;
      end
      quot_d = {quot_q[ebbl_pkg::Q_W-2:0], geq};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_LAST) begin
        run_d = 1'b0;
        rv_d  = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      rv_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      run_q <= run_d;
      rv_q  <= rv_d;
      cnt_q <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
    last_q <= last_d;
  end

  assign busy_o      = run_q | rv_q;
  assign res_valid_o = rv_q;
  assign res_o.quot  = quot_q;
  assign res_o.last  = last_q;

endmodule

// File: test/blur_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_line_checker
// Watches the pixel, result and radius channels of the line box blur block.
// Every accepted pixel beat runs through a local copy of the clipped-window
// mean, and the results it produces are queued. Every accepted result beat
// is compared field by field with the oldest queued mean.
// ----------------------------------------------------------------------------
module blur_line_checker
  import ebbl_pkg::*;
#(
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // pixel stream
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [PIX_W-1:0] s_axis_tdata,  // [7:0] pixel_in
  input  logic             s_axis_tlast,
  // result stream
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [PIX_W-1:0] m_axis_tdata,  // [7:0] pixel_out
  input  logic             m_axis_tlast,
  // radius write
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  logic [RAD_W-1:0] cfg_data_i,
  // status to the top
  output int               fail_cnt_o,
  output int               pending_o
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } blur_out_t;

  // local copy of the line state
  logic [PIX_W-1:0]  ring_mem [128];
  logic [SUM_W-1:0]  win_sum;
  logic [SEEN_W-1:0] seen_cnt;
  logic [6:0]        wr_ptr;
  logic [RAD_W-1:0]  rad_reg;
  logic [RAD_W-1:0]  line_rad;

  blur_out_t mean_q [$];
  blur_out_t mean_want;
  int        out_beats;

  // pixel d places before the newest one written
  function automatic logic [PIX_W-1:0] older_pixel(int d);
    logic [6:0] idx;
    idx = wr_ptr - 7'd1 - 7'(d);
    return ring_mem[idx];
  endfunction

  task automatic push_mean(int div, logic last);
    blur_out_t b;
    b.pix  = PIX_W'(int'(win_sum) / div);
    b.last = last;
    mean_q.push_back(b);
  endtask

  task automatic report_error(string msg);
    $display("%0t ns  beat %0d: %s", $time, out_beats, msg);
    fail_cnt_o++;
  endtask

  // one accepted pixel: update the window and queue the means it releases
  task automatic take_pixel(logic [PIX_W-1:0] pix, logic eol);
    int r;
    int n;
    int kc;
    int k;
    if (seen_cnt == '0) begin
      line_rad = (int'(rad_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : rad_reg;
    end
    r = line_rad;
    n = seen_cnt;
    ring_mem[wr_ptr] = pix;
    wr_ptr  = wr_ptr + 7'd1;
    win_sum = win_sum + SUM_W'(pix);
    if (n >= 2 * r + 1) win_sum = win_sum - SUM_W'(older_pixel(2 * r + 1));
    // position n-r is complete once pixel n is in
    if (n >= r) push_mean((((n - r) < r) ? n - r : r) + r + 1, eol && (r == 0));
    if (eol) begin
      // flush the positions still waiting for right-hand neighbors
      kc = (n >= r) ? r : n + 1;
      for (int i = 0; i < kc; i++) begin
        k = kc - 1 - i;
        if (n - k >= r + 1) win_sum = win_sum - SUM_W'(older_pixel(k + r + 1));
        push_mean((((n - k) < r) ? n - k : r) + 1 + k, k == 0);
      end
      win_sum  = '0;
      seen_cnt = '0;
      wr_ptr   = '0;
    end else if (seen_cnt != SEEN_MAX) begin
      seen_cnt = seen_cnt + 1'b1;
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (ring_mem[i]) ring_mem[i] = '0;
      win_sum    = '0;
      seen_cnt   = '0;
      wr_ptr     = '0;
      rad_reg    = '0;
      line_rad   = '0;
      mean_q.delete();
      out_beats  = 0;
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (mean_q.size() == 0) begin
          report_error($sformatf("result %0d with nothing outstanding", m_axis_tdata));
        end else begin
          mean_want = mean_q.pop_front();
          if (m_axis_tdata !== mean_want.pix) begin
            report_error($sformatf("pixel_out %0d, predicted %0d",
                                   m_axis_tdata, mean_want.pix));
          end
          if (m_axis_tlast !== mean_want.last) begin
            report_error($sformatf("last_of_line %0b, predicted %0b",
                                   m_axis_tlast, mean_want.last));
          end
        end
        out_beats++;
      end
      if (cfg_valid_i && cfg_ready_o) rad_reg = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata, s_axis_tlast);
      pending_o = mean_q.size();
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the line box blur block: a short directed set of lines
// (pass-through, short lines, extreme pixels, radius write inside a line),
// then random lines over several radii with random source and sink gaps and
// one long sink hold-off. Checking is done by blur_line_checker.
// ----------------------------------------------------------------------------
module tb;
  import ebbl_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 300;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [PIX_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;
  logic             cfg_valid_i   = 1'b0;
  logic             cfg_ready_o;
  logic [RAD_W-1:0] cfg_data_i    = '0;

  // radius last written, for line length choice only
  logic [RAD_W-1:0] dut_radius_shadow;

  int fail_cnt;
  int pending;
  int src_idle_pct = 23;
  int snk_idle_pct = 52;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  edge_normalized_box_blur_line dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  blur_line_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  // sink side: random ready, or a long hold-off when one is requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one pixel beat, with random source gaps in front
  task automatic send_pixel(logic [PIX_W-1:0] pix, logic eol);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop the source and wait until every predicted result is out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_radius(logic [RAD_W-1:0] rad);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= rad;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    int u;
    u = $urandom_range(0, 99);
    if (u < 8) return '0;
    if (u < 16) return '1;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  task automatic send_line(int len);
    for (int i = 0; i < len; i++) send_pixel(rand_pixel(), i == len - 1);
  endtask

  // line length biased around the window size, long lines kept rare
  function automatic int pick_len(int rad);
    int u;
    u = $urandom_range(0, 99);
    if (rad == 63) return (u < 85) ? $urandom_range(1, 20) : $urandom_range(64, 150);
    if (u < 70) return $urandom_range(1, 2 * rad + 4);
    if (u < 90) return $urandom_range(2 * rad + 5, 4 * rad + 20);
    return $urandom_range(1, 40);
  endfunction

  function automatic int pick_radius();
    int u;
    u = $urandom_range(0, 99);
    if (u < 10) return 0;
    if (u < 20) return 63;
    if (u < 30) return $urandom_range(13, 62);
    return $urandom_range(1, 12);
  endfunction

  // random lines over several radii, one radius per group of lines
  task automatic run_phase(int items, bit with_hold);
    int sent;
    int grp;
    int len;
    sent = 0;
    while (sent < items) begin
      write_radius(RAD_W'(pick_radius()));
      if (with_hold && sent == 0) hold_req++;
      grp = 0;
      while (grp < 30) begin
        len = pick_len(dut_radius_shadow);
        send_line(len);
        grp  += len;
      end
      sent += grp;
    end
  endtask

  always @(posedge clk_i) begin
    if (cfg_valid_i && cfg_ready_o) dut_radius_shadow <= cfg_data_i;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // pass-through at radius zero, extreme pixels, single-pixel line
    write_radius(6'd0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'hAA, 1'b1);
    send_pixel(8'h55, 1'b1);
    // line shorter than the radius
    write_radius(6'd63);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd1, 1'b1);
    // alternating extremes and a single pixel with a small window
    write_radius(6'd2);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b1);
    send_pixel(8'd200, 1'b1);
    // radius written inside a line applies from the next line
    write_radius(6'd3);
    send_pixel(8'd10, 1'b0);
    send_pixel(8'd20, 1'b0);
    write_radius(6'd1);
    send_pixel(8'd30, 1'b0);
    send_pixel(8'd40, 1'b0);
    send_pixel(8'd50, 1'b1);
    send_pixel(8'd60, 1'b0);
    send_pixel(8'd70, 1'b0);
    send_pixel(8'd80, 1'b1);

    // sender gaps 23, receiver gaps 52; starts with a line past saturation
    src_idle_pct = 23;
    snk_idle_pct = 52;
    write_radius(6'd63);
    send_line(150);
    run_phase(10, 1'b0);
    // swapped gaps
    src_idle_pct = 52;
    snk_idle_pct = 23;
    run_phase(100, 1'b0);
    // no gaps, with one long receiver hold-off
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(100, 1'b1);

    wait_idle();
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
